/* hw/rtl/sps_pkg.sv */
// shared types, codes and phase tables for the stepper phase sequencer
`timescale 1ns / 1ps

package sps_pkg;

    localparam int POSITION_WIDTH = 32;
    localparam int PERIOD_WIDTH   = 20;
    localparam int LOCK_WIDTH     = 26;
    localparam int MOVES_WIDTH    = 32;

    localparam logic [PERIOD_WIDTH-1:0] ELAPSED_MAX = '1;
    localparam logic [LOCK_WIDTH-1:0]   LOCK_MAX    = '1;

    // item function codes
    localparam logic [2:0] FUNC_TICK  = 3'd0;
    localparam logic [2:0] FUNC_MOVE  = 3'd1;
    localparam logic [2:0] FUNC_START = 3'd2;
    localparam logic [2:0] FUNC_STOP  = 3'd3;
    localparam logic [2:0] FUNC_DIR   = 3'd4;

    // run states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_INIT = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_STOP = 2'd3;

    // step modes
    localparam logic [1:0] MODE_WAVE    = 2'd0;
    localparam logic [1:0] MODE_FULL    = 2'd1;
    localparam logic [1:0] MODE_HALF    = 2'd2;
    localparam logic [1:0] MODE_INVALID = 2'd3;

    // register indexes
    localparam logic [1:0] REG_MODE    = 2'd0;
    localparam logic [1:0] REG_PERIOD  = 2'd1;
    localparam logic [1:0] REG_HOLD    = 2'd2;
    localparam logic [1:0] REG_RELEASE = 2'd3;

    localparam logic [LOCK_WIDTH-1:0] RELEASE_RESET = LOCK_WIDTH'(20000);

    typedef struct packed {
        logic [1:0]                run_state;
        logic [2:0]                phase;
        logic [POSITION_WIDTH-1:0] position;
        logic [MOVES_WIDTH-1:0]    moves;
        logic                      move_active;
        logic                      dir_forward;
        logic                      busy;
        logic                      lock;
        logic [3:0]                coils;
        logic [PERIOD_WIDTH-1:0]   step_elapsed;
        logic                      first_step_due;
        logic [LOCK_WIDTH-1:0]     lock_elapsed;
    } state_t;

    typedef struct packed {
        logic [1:0]              mode;
        logic [PERIOD_WIDTH-1:0] period;
        logic                    hold;
        logic [LOCK_WIDTH-1:0]   release_ticks;
    } cfg_t;

    // reset values, fields in declaration order
    localparam state_t STATE_RESET = {ST_IDLE, 3'd0, {POSITION_WIDTH{1'b0}},
                                      {MOVES_WIDTH{1'b0}}, 1'b0, 1'b1, 1'b0, 1'b0,
                                      4'h0, {PERIOD_WIDTH{1'b0}}, 1'b0,
                                      {LOCK_WIDTH{1'b0}}};
    localparam cfg_t   CFG_RESET   = {MODE_HALF, {PERIOD_WIDTH{1'b0}}, 1'b0,
                                      RELEASE_RESET};

    // coil nibble for a mode and phase; odd phases take the high nibble
    function automatic logic [3:0] coil_pattern(input logic [1:0] mode,
                                                input logic [2:0] phase);
        logic [7:0] pat;
        pat = 8'h00;
        unique case (mode)
            MODE_WAVE: begin
                pat = phase[1] ? 8'h84 : 8'h21;
            end
            MODE_FULL: begin
                pat = phase[1] ? 8'h9c : 8'h63;
            end
            MODE_HALF, MODE_INVALID: begin
                unique case (phase[2:1])
                    2'd0: pat = 8'h31;
                    2'd1: pat = 8'h62;
                    2'd2: pat = 8'hc4;
                    default: pat = 8'h98;
                endcase
            end
        endcase
        return phase[0] ? pat[7:4] : pat[3:0];
    endfunction

endpackage

/* hw/rtl/sps_step_logic.sv */
// next-state logic for one item: ticks, commands and the step itself
`timescale 1ns / 1ps

module sps_step_logic (
    input  sps_pkg::state_t  state_i,
    input  sps_pkg::cfg_t    cfg_i,
    input  logic [2:0]       func_i,
    input  logic [31:0]      distance_i,
    input  logic             forward_i,
    output sps_pkg::state_t  state_o,
    output logic             stepped_o
);

    always_comb begin
        sps_pkg::state_t                         nx;
        logic [sps_pkg::LOCK_WIDTH-1:0]          lock_inc;
        logic [sps_pkg::PERIOD_WIDTH-1:0]        el_inc;
        logic [sps_pkg::MOVES_WIDTH-1:0]         moves_dec;
        logic                                    do_step;

        nx        = state_i;
        do_step   = 1'b0;
        lock_inc  = (state_i.lock_elapsed < sps_pkg::LOCK_MAX) ?
                    state_i.lock_elapsed + 1'b1 : state_i.lock_elapsed;
        el_inc    = (state_i.step_elapsed < sps_pkg::ELAPSED_MAX) ?
                    state_i.step_elapsed + 1'b1 : state_i.step_elapsed;
        moves_dec = state_i.moves - 1'b1;

        unique case (func_i)
            sps_pkg::FUNC_TICK: begin
                nx.lock_elapsed = lock_inc;
                unique case (state_i.run_state)
                    sps_pkg::ST_IDLE: begin
                        if (!cfg_i.hold && state_i.lock &&
                            lock_inc >= cfg_i.release_ticks) begin
                            nx.coils = 4'h0;
                            nx.lock  = 1'b0;
                        end
                    end
                    sps_pkg::ST_INIT: begin
                        if (cfg_i.period == '0 ||
                            (state_i.move_active && state_i.moves == '0)) begin
                            if (state_i.moves == '0) begin
                                nx.move_active = 1'b0;
                            end
                            nx.run_state = sps_pkg::ST_IDLE;
                        end else begin
                            nx.busy           = 1'b1;
                            nx.lock           = 1'b0;
                            nx.run_state      = sps_pkg::ST_RUN;
                            nx.first_step_due = 1'b1;
                        end
                    end
                    sps_pkg::ST_RUN: begin
                        if (state_i.first_step_due) begin
                            do_step = 1'b1;
                        end else begin
                            nx.step_elapsed = el_inc;
                            do_step = (el_inc >= cfg_i.period);
                        end
                    end
                    sps_pkg::ST_STOP: begin
                        nx.busy         = 1'b0;
                        nx.move_active  = 1'b0;
                        nx.lock         = 1'b1;
                        nx.run_state    = sps_pkg::ST_IDLE;
                        nx.lock_elapsed = '0;
                    end
                endcase
            end
            sps_pkg::FUNC_MOVE: begin
                nx.dir_forward = (distance_i != '0) && !distance_i[31];
                nx.moves       = distance_i[31] ? (32'd0 - distance_i) : distance_i;
                nx.move_active = (distance_i != '0);
            end
            sps_pkg::FUNC_START: begin
                nx.run_state = sps_pkg::ST_INIT;
            end
            sps_pkg::FUNC_STOP: begin
                nx.run_state = sps_pkg::ST_STOP;
            end
            sps_pkg::FUNC_DIR: begin
                nx.dir_forward = forward_i;
            end
            default: begin
            end
        endcase

        if (do_step) begin
            nx.coils = sps_pkg::coil_pattern(cfg_i.mode, state_i.phase);
            if (state_i.dir_forward) begin
                nx.phase    = state_i.phase + 3'd1;
                nx.position = state_i.position + 1'b1;
            end else begin
                nx.phase    = state_i.phase - 3'd1;
                nx.position = state_i.position - 1'b1;
            end
            nx.step_elapsed   = '0;
            nx.first_step_due = 1'b0;
            if (state_i.move_active) begin
                nx.moves = moves_dec;
                if (moves_dec == '0) begin
                    nx.run_state = sps_pkg::ST_STOP;
                end
            end
        end

        state_o   = nx;
        stepped_o = do_step;
    end

endmodule

/* hw/rtl/stepper_phase_sequencer.sv */
// top level of the stepper phase sequencer: channels, state and registers
`timescale 1ns / 1ps

// Drives four unipolar stepper coils from a phase index in wave, full or
// half step mode. Each input item is either a one-microsecond tick (func 0)
// or a command: move by a signed distance, start, stop or set direction.
// Ticks advance the run state machine; only ticks advance the step and lock timers.
// Every item gives exactly one result item with the coil bits, busy, locked,
// stepped, the wrapping position and the steps left of the current move.
// An item passes an input register and a result register, and one item is
// taken every cycle while the receiver takes results. When the receiver
// stalls the result is held, the input register takes at most one more
// item, and s_axis_tready drops while that register is full.
// Registers sit on the APB port: step mode, step period, hold lock and
// lock release ticks; writing a valid mode puts the phase back to 0.
// Reset puts the block in idle with coils off, position 0, direction
// forward, half step mode, no speed and a release time of 20000 ticks.

module stepper_phase_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // distance[31:0], forward[32], zero pad
    input  logic [2:0]  s_axis_tuser,   // func[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // coils[3:0], busy_res[4], locked[5],
                                        // stepped[6], position[38:7],
                                        // moves_left[70:39], zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    sps_pkg::state_t state_reg, state_next, core_state;
    sps_pkg::cfg_t   cfg_reg, cfg_next;
    logic            core_stepped;

    logic        in_valid_reg;
    logic [2:0]  in_func_reg;
    logic [31:0] in_dist_reg;
    logic        in_fwd_reg;

    logic        out_valid_reg;
    logic [3:0]  out_coils_reg;
    logic        out_busy_reg;
    logic        out_locked_reg;
    logic        out_stepped_reg;
    logic [31:0] out_position_reg;
    logic [31:0] out_moves_reg;

    logic advance;
    logic s_accept;
    logic cfg_write;
    logic [1:0] reg_index;

    assign advance   = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept  = s_axis_tvalid && s_axis_tready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[3:2];

    sps_step_logic u_step_logic (
        .state_i    (state_reg),
        .cfg_i      (cfg_reg),
        .func_i     (in_func_reg),
        .distance_i (in_dist_reg),
        .forward_i  (in_fwd_reg),
        .state_o    (core_state),
        .stepped_o  (core_stepped)
    );

    // item update first, then register writes
    always_comb begin
        state_next = advance ? core_state : state_reg;
        cfg_next   = cfg_reg;
        if (cfg_write) begin
            unique case (reg_index)
                sps_pkg::REG_MODE: begin
                    if (pwdata[1:0] != sps_pkg::MODE_INVALID) begin
                        cfg_next.mode    = pwdata[1:0];
                        state_next.phase = 3'd0;
                    end
                end
                sps_pkg::REG_PERIOD: begin
                    if (pwdata[sps_pkg::PERIOD_WIDTH-1:0] != cfg_reg.period) begin
                        cfg_next.period = pwdata[sps_pkg::PERIOD_WIDTH-1:0];
                        if (pwdata[sps_pkg::PERIOD_WIDTH-1:0] == '0) begin
                            state_next.run_state = sps_pkg::ST_STOP;
                        end
                    end
                end
                sps_pkg::REG_HOLD: begin
                    cfg_next.hold = pwdata[0];
                    if (pwdata[0] && !state_reg.busy) begin
                        state_next.lock_elapsed = '0;
                    end
                end
                sps_pkg::REG_RELEASE: begin
                    cfg_next.release_ticks = pwdata[sps_pkg::LOCK_WIDTH-1:0];
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            sps_pkg::REG_MODE:    prdata = {30'd0, cfg_reg.mode};
            sps_pkg::REG_PERIOD:  prdata = 32'(cfg_reg.period);
            sps_pkg::REG_HOLD:    prdata = {31'd0, cfg_reg.hold};
            sps_pkg::REG_RELEASE: prdata = 32'(cfg_reg.release_ticks);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sps_pkg::STATE_RESET;
            cfg_reg       <= sps_pkg::CFG_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cfg_reg   <= cfg_next;
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_func_reg <= s_axis_tuser;
            in_dist_reg <= s_axis_tdata[31:0];
            in_fwd_reg  <= s_axis_tdata[32];
        end
        if (advance) begin
            out_coils_reg    <= core_state.coils;
            out_busy_reg     <= core_state.busy;
            out_locked_reg   <= core_state.lock;
            out_stepped_reg  <= core_stepped;
            out_position_reg <= 32'($signed(core_state.position));
            out_moves_reg    <= core_state.moves;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_moves_reg, out_position_reg, out_stepped_reg,
                            out_locked_reg, out_busy_reg, out_coils_reg};

`ifndef NO_ASSERTIONS
    // a step only happens while running
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_stepped_reg |-> out_busy_reg)
        else $error("step reported while not busy");

    // coils are never both held after stop and running
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_busy_reg && out_locked_reg))
        else $error("busy and locked at the same time");

    // commands never take a step
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_func_reg != sps_pkg::FUNC_TICK |=> !out_stepped_reg)
        else $error("step reported for a command item");
`endif

endmodule

/* tb/tb_stepper_phase_sequencer.sv */
// self-checking testbench for the stepper phase sequencer: random commands and ticks
`timescale 1ns / 1ps

module tb_stepper_phase_sequencer;
    import sps_pkg::*;

    localparam int QUIET_LIMIT  = 1000;
    localparam int PHASE_ITEMS  = 150;
    localparam int RANDOM_SETS  = 8;

    typedef struct {
        logic [2:0]  func;
        logic [31:0] distance;
        logic        forward;
    } motion_item_t;

    typedef struct {
        logic [3:0]  coils;
        logic        busy;
        logic        locked;
        logic        stepped;
        logic [31:0] position;
        logic [31:0] moves_left;
    } motor_status_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;   // distance[31:0], forward[32], zero pad
    logic [2:0]  s_axis_tuser  = '0;   // func[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;         // coils[3:0], busy_res[4], locked[5], stepped[6],
                                       // position[38:7], moves_left[70:39], zero pad
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [3:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    stepper_phase_sequencer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predicted motor state and settings
    logic [1:0]              m_run      = ST_IDLE;
    logic [2:0]              m_phase    = '0;
    logic [31:0]             m_position = '0;
    logic [31:0]             m_moves    = '0;
    logic                    m_counted  = 1'b0;
    logic                    m_forward  = 1'b1;
    logic                    m_busy     = 1'b0;
    logic                    m_lock     = 1'b0;
    logic [3:0]              m_coils    = '0;
    logic [PERIOD_WIDTH-1:0] m_since    = '0;
    logic                    m_first    = 1'b0;
    logic [LOCK_WIDTH-1:0]   m_idle     = '0;

    logic [1:0]              set_mode    = MODE_HALF;
    logic [PERIOD_WIDTH-1:0] set_period  = '0;
    logic                    set_hold    = 1'b0;
    logic [LOCK_WIDTH-1:0]   set_release = RELEASE_RESET;

    logic [7:0] coil_table [3][4] = '{'{8'h21, 8'h84, 8'h21, 8'h84},
                                      '{8'h63, 8'h9c, 8'h63, 8'h9c},
                                      '{8'h31, 8'h62, 8'hc4, 8'h98}};

    motion_item_t  pending_items [$];
    motor_status_t expected_status [$];
    motion_item_t  in_flight;
    motor_status_t want;
    motor_status_t got;

    int  send_gap;
    int  stall_left;
    int  quiet_cycles;
    int  failures;
    int  queued_count;
    int  items_accepted;
    int  results_checked;
    int  steps_seen;
    int  settings_written;
    bit  calm;

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic advance_motor(input motion_item_t it, output motor_status_t st);
        logic       stepped;
        logic [7:0] pat;
        stepped = 1'b0;
        case (it.func)
            FUNC_TICK: begin
                if (m_idle != LOCK_MAX)
                    m_idle++;
                case (m_run)
                    ST_IDLE: begin
                        if (!set_hold && m_lock && m_idle >= set_release) begin
                            m_coils = '0;
                            m_lock  = 1'b0;
                        end
                    end
                    ST_INIT: begin
                        if (set_period == 0 || (m_counted && m_moves == 0)) begin
                            if (m_moves == 0)
                                m_counted = 1'b0;
                            m_run = ST_IDLE;
                        end else begin
                            m_busy  = 1'b1;
                            m_lock  = 1'b0;
                            m_run   = ST_RUN;
                            m_first = 1'b1;
                        end
                    end
                    ST_RUN: begin
                        if (!m_first && m_since != ELAPSED_MAX)
                            m_since++;
                        if (m_first || m_since >= set_period) begin
                            stepped = 1'b1;
                            pat     = coil_table[set_mode][m_phase[2:1]];
                            m_coils = m_phase[0] ? pat[7:4] : pat[3:0];
                            if (m_forward) begin
                                m_phase    = m_phase + 3'd1;
                                m_position = m_position + 32'd1;
                            end else begin
                                m_phase    = m_phase - 3'd1;
                                m_position = m_position - 32'd1;
                            end
                            m_since = '0;
                            m_first = 1'b0;
                            if (m_counted) begin
                                m_moves = m_moves - 32'd1;
                                if (m_moves == 0)
                                    m_run = ST_STOP;
                            end
                        end
                    end
                    default: begin
                        m_busy    = 1'b0;
                        m_counted = 1'b0;
                        m_lock    = 1'b1;
                        m_run     = ST_IDLE;
                        m_idle    = '0;
                    end
                endcase
            end
            FUNC_MOVE: begin
                m_forward = (it.distance != 0) && !it.distance[31];
                m_moves   = it.distance[31] ? 32'd0 - it.distance : it.distance;
                m_counted = (it.distance != 0);
            end
            FUNC_START: m_run = ST_INIT;
            FUNC_STOP:  m_run = ST_STOP;
            FUNC_DIR:   m_forward = it.forward;
            default: ;
        endcase
        st.coils      = m_coils;
        st.busy       = m_busy;
        st.locked     = m_lock;
        st.stepped    = stepped;
        st.position   = m_position;
        st.moves_left = m_moves;
    endtask

    task automatic apply_register(input logic [1:0] idx, input logic [31:0] value);
        case (idx)
            REG_MODE: begin
                if (value[1:0] != MODE_INVALID) begin
                    set_mode = value[1:0];
                    m_phase  = '0;
                end
            end
            REG_PERIOD: begin
                if (value[PERIOD_WIDTH-1:0] != set_period) begin
                    set_period = value[PERIOD_WIDTH-1:0];
                    if (set_period == 0)
                        m_run = ST_STOP;
                end
            end
            REG_HOLD: begin
                set_hold = value[0];
                if (set_hold && !m_busy)
                    m_idle = '0;
            end
            default: set_release = value[LOCK_WIDTH-1:0];
        endcase
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        apply_register(idx, value);
        settings_written++;
    endtask

    task automatic queue_item(input logic [2:0] func, input logic [31:0] distance,
                              input logic forward);
        motion_item_t it;
        it.func     = func;
        it.distance = distance;
        it.forward  = forward;
        pending_items.push_back(it);
        if (func <= FUNC_DIR)
            queued_count++;
    endtask

    // block until every item is in and every result is out
    task automatic wait_quiet();
        @(negedge aclk);
        while (pending_items.size() != 0 || s_axis_tvalid || expected_status.size() != 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // driver: predict on acceptance, then present the next item after a gap
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                advance_motor(in_flight, want);
                expected_status.push_back(want);
                items_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    in_flight = pending_items.pop_front();
                    s_axis_tdata  <= {7'b0, in_flight.forward, in_flight.distance};
                    s_axis_tuser  <= in_flight.func;
                    s_axis_tvalid <= 1'b1;
                    send_gap = pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: random back-pressure and field-by-field comparison
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.coils      = m_axis_tdata[3:0];
                got.busy       = m_axis_tdata[4];
                got.locked     = m_axis_tdata[5];
                got.stepped    = m_axis_tdata[6];
                got.position   = m_axis_tdata[38:7];
                got.moves_left = m_axis_tdata[70:39];
                if (expected_status.size() == 0) begin
                    $error("result item with nothing expected: %h", m_axis_tdata);
                    failures++;
                end else begin
                    want = expected_status.pop_front();
                    results_checked++;
                    if (got.stepped)
                        steps_seen++;
                    if (got.coils !== want.coils) begin
                        $error("coils: expected %h, got %h", want.coils, got.coils);
                        failures++;
                    end
                    if (got.busy !== want.busy) begin
                        $error("busy_res: expected %b, got %b", want.busy, got.busy);
                        failures++;
                    end
                    if (got.locked !== want.locked) begin
                        $error("locked: expected %b, got %b", want.locked, got.locked);
                        failures++;
                    end
                    if (got.stepped !== want.stepped) begin
                        $error("stepped: expected %b, got %b", want.stepped, got.stepped);
                        failures++;
                    end
                    if (got.position !== want.position) begin
                        $error("position: expected %h, got %h", want.position, got.position);
                        failures++;
                    end
                    if (got.moves_left !== want.moves_left) begin
                        $error("moves_left: expected %h, got %h",
                               want.moves_left, got.moves_left);
                        failures++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || psel || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int          ph;
        int          r;
        logic [31:0] mag;
        logic [31:0] move_len;
        logic [31:0] period;
        logic [31:0] release_ticks;

        calm = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: no speed, so start falls back to idle; unknown funcs ignored
        queue_item(FUNC_START, $urandom, 1'b0);
        queue_item(FUNC_TICK, $urandom, 1'b1);
        queue_item(3'd5, $urandom, 1'b1);
        queue_item(3'd6, $urandom, 1'b0);
        queue_item(3'd7, 32'hffff_ffff, 1'b1);
        wait_quiet();

        write_register(REG_MODE, {30'b0, MODE_INVALID});
        write_register(REG_MODE, {30'b0, MODE_WAVE});
        write_register(REG_PERIOD, 32'd1);
        write_register(REG_HOLD, 32'd0);
        write_register(REG_RELEASE, 32'd2);

        // counted move to its end, stop, lock release, then the distance extremes
        queue_item(FUNC_MOVE, 32'd3, 1'b0);
        queue_item(FUNC_START, 32'd0, 1'b0);
        repeat (8) queue_item(FUNC_TICK, 32'd0, 1'b0);
        queue_item(FUNC_MOVE, 32'd0, 1'b1);
        queue_item(FUNC_MOVE, 32'h8000_0000, 1'b0);
        queue_item(FUNC_DIR, 32'hffff_ffff, 1'b1);
        queue_item(FUNC_MOVE, 32'h7fff_ffff, 1'b1);
        queue_item(FUNC_START, 32'h0, 1'b0);
        repeat (2) queue_item(FUNC_TICK, 32'h0, 1'b0);
        queue_item(FUNC_STOP, 32'h0, 1'b0);
        queue_item(FUNC_TICK, 32'h0, 1'b0);
        wait_quiet();

        for (ph = 0; ph < RANDOM_SETS; ph++) begin
            if (ph == 0) begin
                write_register(REG_MODE, {30'b0, MODE_WAVE});
                write_register(REG_PERIOD, 32'd1);
                write_register(REG_HOLD, 32'd0);
                write_register(REG_RELEASE, 32'd0);
            end else if (ph == 1) begin
                write_register(REG_MODE, {30'b0, MODE_FULL});
                write_register(REG_PERIOD, 32'd1000000);
                write_register(REG_HOLD, 32'd1);
                write_register(REG_RELEASE, {6'b0, LOCK_MAX});
            end else begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    period = 32'd0;
                else if (r < 80)
                    period = $urandom_range(1, 6);
                else if (r < 95)
                    period = $urandom_range(7, 30);
                else
                    period = 32'd1000000;
                r = $urandom_range(0, 99);
                if (r < 70)
                    release_ticks = $urandom_range(0, 30);
                else if (r < 85)
                    release_ticks = $urandom_range(0, 67108863);
                else
                    release_ticks = {6'b0, LOCK_MAX};
                write_register(REG_MODE, $urandom_range(0, 3));
                write_register(REG_PERIOD, period);
                write_register(REG_HOLD, $urandom_range(0, 1));
                write_register(REG_RELEASE, release_ticks);
            end
            calm = (ph == 0) || ($urandom_range(0, 3) == 0);
            queued_count = 0;
            while (queued_count < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    // counted move: optional direction, move, start, ticks, maybe a stop
                    if ($urandom_range(0, 3) == 0)
                        queue_item(FUNC_DIR, $urandom, 1'($urandom_range(0, 1)));
                    r = $urandom_range(0, 99);
                    mag = $urandom_range(1, 12);
                    if (r < 80)
                        move_len = $urandom_range(0, 1) ? 32'd0 - mag : mag;
                    else if (r < 88)
                        move_len = 32'd0;
                    else if (r < 92)
                        move_len = 32'h8000_0000;
                    else if (r < 96)
                        move_len = 32'h7fff_ffff;
                    else
                        move_len = $urandom;
                    queue_item(FUNC_MOVE, move_len, 1'($urandom_range(0, 1)));
                    queue_item(FUNC_START, $urandom, 1'($urandom_range(0, 1)));
                    repeat ($urandom_range(1, 40)) queue_item(FUNC_TICK, $urandom, 1'b0);
                    if ($urandom_range(0, 4) == 0) begin
                        queue_item(FUNC_STOP, $urandom, 1'($urandom_range(0, 1)));
                        repeat ($urandom_range(1, 5)) queue_item(FUNC_TICK, $urandom, 1'b1);
                    end
                end else if (r < 85) begin
                    // free run with no new move, ended by a stop
                    queue_item(FUNC_DIR, $urandom, 1'($urandom_range(0, 1)));
                    queue_item(FUNC_START, $urandom, 1'($urandom_range(0, 1)));
                    repeat ($urandom_range(1, 30)) queue_item(FUNC_TICK, $urandom, 1'b0);
                    queue_item(FUNC_STOP, $urandom, 1'($urandom_range(0, 1)));
                    repeat ($urandom_range(1, 30)) queue_item(FUNC_TICK, $urandom, 1'b1);
                end else begin
                    repeat ($urandom_range(1, 6))
                        queue_item(3'($urandom_range(0, 7)), $urandom,
                                   1'($urandom_range(0, 1)));
                end
            end
            wait_quiet();
        end

        repeat (10) @(posedge aclk);
        $display("ran %0d items through the sequencer, %0d results checked, %0d with a step",
                 items_accepted, results_checked, steps_seen);
        $display("%0d register writes across wave, full and half step and the period extremes",
                 settings_written);
        if (failures == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/sps_pkg.sv
hw/rtl/sps_step_logic.sv
hw/rtl/stepper_phase_sequencer.sv
tb/tb_stepper_phase_sequencer.sv
